@@ rtl/cfhl_pkg.sv @@
package cfhl_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgAutoMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLightLowLux  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLightHighLux = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTempLow      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTempHigh     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAmmoniaLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSulfideLimit = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWarmupMs     = 3'd7;

  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic               AutoModeRst     = 1'b1;
  localparam logic [15:0]        LightLowRst     = 16'd80;
  localparam logic [15:0]        LightHighRst    = 16'd500;
  localparam logic signed [11:0] TempLowRst      = 12'sd200;
  localparam logic signed [11:0] TempHighRst     = 12'sd250;
  localparam logic [15:0]        AmmoniaLimitRst = 16'd1500;
  localparam logic [15:0]        SulfideLimitRst = 16'd800;
  localparam logic [31:0]        WarmupMsRst     = 32'd60000;

  // Fan levels and their PWM duty (percent * 255 / 100)
  localparam logic [6:0] FanPctFull = 7'd100;
  localparam logic [6:0] FanPctLow  = 7'd10;
  localparam logic [7:0] FanDutyFull = 8'(100 * 255 / 100);
  localparam logic [7:0] FanDutyLow  = 8'(10 * 255 / 100);

  // Change mask bit positions
  localparam int unsigned ChgFan     = 0;
  localparam int unsigned ChgHeater  = 1;
  localparam int unsigned ChgLamp    = 2;
  localparam int unsigned ChgCurtain = 3;

  typedef struct packed {
    logic               auto_ctrl;
    logic [15:0]        light_low_lux;
    logic [15:0]        light_high_lux;
    logic signed [11:0] temp_low_tenths;
    logic signed [11:0] temp_high_tenths;
    logic [15:0]        ammonia_limit;
    logic [15:0]        sulfide_limit;
    logic [31:0]        warmup_ms;
  } cfg_t;

  typedef struct packed {
    logic [6:0] fan_level;
    logic       fan_level_known;
    logic       heater_state;
    logic       lamp_state;
    logic       curtain_state;
    logic       closed_for_glare;
  } state_t;

  typedef struct packed {
    logic [31:0]        elapsed_ms;
    logic signed [11:0] temperature_tenths;
    logic [15:0]        ammonia_level;
    logic [15:0]        sulfide_level;
    logic [15:0]        light_lux;
  } item_t;

  typedef struct packed {
    logic [6:0] fan_speed_pct;
    logic [7:0] fan_duty;
    logic       heater_on;
    logic       lamp_on;
    logic       shade_open;
    logic [3:0] change_mask;
  } result_t;

endpackage

@@ rtl/cfhl_decide.sv @@
module cfhl_decide (
  input  cfhl_pkg::cfg_t    cfg_i,
  input  cfhl_pkg::state_t  state_i,
  input  cfhl_pkg::item_t   item_i,
  output cfhl_pkg::state_t  state_o,
  output cfhl_pkg::result_t result_o
);

  logic gas_alarm;
  logic cold;
  logic hot;
  logic fan_full;
  logic [6:0] pct;
  logic too_bright;
  logic too_dark;
  cfhl_pkg::state_t nxt;

  // Classify the tick
  always_comb begin
    gas_alarm = (item_i.elapsed_ms >= cfg_i.warmup_ms) &&
                ((item_i.ammonia_level > cfg_i.ammonia_limit) ||
                 (item_i.sulfide_level > cfg_i.sulfide_limit));
    cold       = item_i.temperature_tenths < cfg_i.temp_low_tenths;
    hot        = item_i.temperature_tenths > cfg_i.temp_high_tenths;
    fan_full   = gas_alarm || (!cold && hot);
    pct        = fan_full ? cfhl_pkg::FanPctFull : cfhl_pkg::FanPctLow;
    too_bright = item_i.light_lux > cfg_i.light_high_lux;
    too_dark   = item_i.light_lux < cfg_i.light_low_lux;
  end

  // Advance the actuator state
  always_comb begin
    nxt = state_i;
    nxt.fan_level       = pct;
    nxt.fan_level_known = 1'b1;
    if (cfg_i.auto_ctrl) begin
      nxt.heater_state = cold;
      if (too_bright) begin
        // lamp goes off first, curtain closes on a later tick
        if (state_i.lamp_state) begin
          nxt.lamp_state = 1'b0;
        end else begin
          nxt.curtain_state    = 1'b0;
          nxt.closed_for_glare = 1'b1;
        end
      end else if (too_dark) begin
        if (!state_i.curtain_state && state_i.closed_for_glare) begin
          nxt.lamp_state = 1'b1;
        end else if (!state_i.curtain_state) begin
          nxt.curtain_state    = 1'b1;
          nxt.closed_for_glare = 1'b0;
          nxt.lamp_state       = 1'b0;
        end else begin
          nxt.lamp_state = 1'b1;
        end
      end
    end
  end

  // Build the result
  always_comb begin
    result_o.fan_speed_pct = pct;
    result_o.fan_duty    = fan_full ? cfhl_pkg::FanDutyFull : cfhl_pkg::FanDutyLow;
    result_o.heater_on   = nxt.heater_state;
    result_o.lamp_on     = nxt.lamp_state;
    result_o.shade_open  = nxt.curtain_state;
    result_o.change_mask = '0;
    result_o.change_mask[cfhl_pkg::ChgFan] =
      !state_i.fan_level_known || (pct != state_i.fan_level);
    result_o.change_mask[cfhl_pkg::ChgHeater] = nxt.heater_state != state_i.heater_state;
    result_o.change_mask[cfhl_pkg::ChgLamp]   = nxt.lamp_state != state_i.lamp_state;
    result_o.change_mask[cfhl_pkg::ChgCurtain] =
      nxt.curtain_state != state_i.curtain_state;
  end

  assign state_o = nxt;

endmodule

@@ rtl/climate_fan_heat_light_controller_core.sv @@
// A request is captured in the input register, then its result moves to the result
// register when that slot is free or draining, and is presented from there.
// Throughput: one request per cycle while the output is not stalled; a stalled result
// leaves room for one more request in the input register, then in_stall_o rises.
// Reset (rst_ni low, asynchronous): both stages empty, actuator state cleared,
// configuration registers back to their documented defaults.
module climate_fan_heat_light_controller_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cfhl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cfhl_pkg::CfgDataW-1:0]       cfg_data_i,
  // sensing tick in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [31:0]                         elapsed_ms_i,
  input  logic signed [11:0]                  temperature_tenths_i,
  input  logic [15:0]                         ammonia_level_i,
  input  logic [15:0]                         sulfide_level_i,
  input  logic [15:0]                         light_lux_i,
  // result out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [6:0]                          fan_speed_pct_o,
  output logic [7:0]                          fan_duty_o,
  output logic                                heater_on_o,
  output logic                                lamp_on_o,
  output logic                                shade_open_o,
  output logic [3:0]                          change_mask_o
);

  cfhl_pkg::cfg_t    cfg_q;
  cfhl_pkg::state_t  state_q;
  cfhl_pkg::state_t  state_d;
  cfhl_pkg::item_t   item_q;
  cfhl_pkg::result_t result_d;
  cfhl_pkg::result_t result_q;
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  // Handshake: advance when the result slot is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_ctrl        <= cfhl_pkg::AutoModeRst;
      cfg_q.light_low_lux    <= cfhl_pkg::LightLowRst;
      cfg_q.light_high_lux   <= cfhl_pkg::LightHighRst;
      cfg_q.temp_low_tenths  <= cfhl_pkg::TempLowRst;
      cfg_q.temp_high_tenths <= cfhl_pkg::TempHighRst;
      cfg_q.ammonia_limit    <= cfhl_pkg::AmmoniaLimitRst;
      cfg_q.sulfide_limit    <= cfhl_pkg::SulfideLimitRst;
      cfg_q.warmup_ms        <= cfhl_pkg::WarmupMsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cfhl_pkg::CfgAutoMode:     cfg_q.auto_ctrl        <= cfg_data_i[0];
        cfhl_pkg::CfgLightLowLux:  cfg_q.light_low_lux    <= cfg_data_i[15:0];
        cfhl_pkg::CfgLightHighLux: cfg_q.light_high_lux   <= cfg_data_i[15:0];
        cfhl_pkg::CfgTempLow:      cfg_q.temp_low_tenths  <= signed'(cfg_data_i[11:0]);
        cfhl_pkg::CfgTempHigh:     cfg_q.temp_high_tenths <= signed'(cfg_data_i[11:0]);
        cfhl_pkg::CfgAmmoniaLimit: cfg_q.ammonia_limit    <= cfg_data_i[15:0];
        cfhl_pkg::CfgSulfideLimit: cfg_q.sulfide_limit    <= cfg_data_i[15:0];
        cfhl_pkg::CfgWarmupMs:     cfg_q.warmup_ms        <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.elapsed_ms         <= elapsed_ms_i;
      item_q.temperature_tenths <= temperature_tenths_i;
      item_q.ammonia_level      <= ammonia_level_i;
      item_q.sulfide_level      <= sulfide_level_i;
      item_q.light_lux          <= light_lux_i;
    end
  end

  cfhl_decide u_decide (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Actuator state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fan_speed_pct_o = result_q.fan_speed_pct;
  assign fan_duty_o      = result_q.fan_duty;
  assign heater_on_o     = result_q.heater_on;
  assign lamp_on_o       = result_q.lamp_on;
  assign shade_open_o    = result_q.shade_open;
  assign change_mask_o   = result_q.change_mask;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import cfhl_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int IdlePct    = 36;

  typedef struct {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // driven ports
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  item_t               drv_tick = '0;
  logic                out_stall = 1'b0;

  // observed ports
  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] fan_speed_pct_o;
  logic [7:0] fan_duty_o;
  logic       heater_on_o;
  logic       lamp_on_o;
  logic       shade_open_o;
  logic [3:0] change_mask_o;

  // pending traffic and predicted results
  item_t      tick_q[$];
  reg_write_t reg_write_q[$];
  result_t    expected_q[$];

  // shadow copy of the controller
  cfg_t   clim_cfg;
  state_t clim_st;

  int n_pushed = 0;
  int n_checked = 0;
  int cfg_pushed = 0;
  int cfg_done = 0;
  int n_fail = 0;
  int n_setups = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  climate_fan_heat_light_controller_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .elapsed_ms_i         (drv_tick.elapsed_ms),
    .temperature_tenths_i (drv_tick.temperature_tenths),
    .ammonia_level_i      (drv_tick.ammonia_level),
    .sulfide_level_i      (drv_tick.sulfide_level),
    .light_lux_i          (drv_tick.light_lux),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .fan_speed_pct_o      (fan_speed_pct_o),
    .fan_duty_o           (fan_duty_o),
    .heater_on_o          (heater_on_o),
    .lamp_on_o            (lamp_on_o),
    .shade_open_o         (shade_open_o),
    .change_mask_o        (change_mask_o)
  );

  // Generate the clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic bit takes_break();
    return !no_idle && ($urandom_range(0, 99) < IdlePct);
  endfunction

  // Write one register of the shadow configuration
  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgAutoMode:     clim_cfg.auto_ctrl = data[0];
      CfgLightLowLux:  clim_cfg.light_low_lux = data[15:0];
      CfgLightHighLux: clim_cfg.light_high_lux = data[15:0];
      CfgTempLow:      clim_cfg.temp_low_tenths = data[11:0];
      CfgTempHigh:     clim_cfg.temp_high_tenths = data[11:0];
      CfgAmmoniaLimit: clim_cfg.ammonia_limit = data[15:0];
      CfgSulfideLimit: clim_cfg.sulfide_limit = data[15:0];
      CfgWarmupMs:     clim_cfg.warmup_ms = data;
      default: ;
    endcase
  endfunction

  // Advance the shadow controller by one sensing tick and build its result
  function automatic result_t climate_tick(item_t t);
    result_t    r;
    state_t     prev;
    logic [6:0] pct;
    int         temp_now;
    int         lo;
    int         hi;
    bit         gas_hot;
    temp_now = $signed(t.temperature_tenths);
    lo = $signed(clim_cfg.temp_low_tenths);
    hi = $signed(clim_cfg.temp_high_tenths);
    prev = clim_st;
    gas_hot = (t.elapsed_ms >= clim_cfg.warmup_ms) &&
              (t.ammonia_level > clim_cfg.ammonia_limit ||
               t.sulfide_level > clim_cfg.sulfide_limit);
    // low limit wins over the high limit when the two are crossed
    if (gas_hot) pct = FanPctFull;
    else if (temp_now < lo) pct = FanPctLow;
    else if (temp_now > hi) pct = FanPctFull;
    else pct = FanPctLow;

    r.change_mask = '0;
    if (!clim_st.fan_level_known || pct != clim_st.fan_level) r.change_mask[ChgFan] = 1'b1;
    clim_st.fan_level = pct;
    clim_st.fan_level_known = 1'b1;

    // step the lamp and curtain toward the light band
    if (clim_cfg.auto_ctrl) begin
      clim_st.heater_state = (temp_now < lo);
      if (t.light_lux > clim_cfg.light_high_lux) begin
        if (clim_st.lamp_state) begin
          clim_st.lamp_state = 1'b0;
        end else begin
          clim_st.curtain_state = 1'b0;
          clim_st.closed_for_glare = 1'b1;
        end
      end else if (t.light_lux < clim_cfg.light_low_lux) begin
        if (clim_st.curtain_state) begin
          clim_st.lamp_state = 1'b1;
        end else if (clim_st.closed_for_glare) begin
          clim_st.lamp_state = 1'b1;
        end else begin
          clim_st.curtain_state = 1'b1;
          clim_st.closed_for_glare = 1'b0;
          clim_st.lamp_state = 1'b0;
        end
      end
    end

    if (clim_st.heater_state != prev.heater_state) r.change_mask[ChgHeater] = 1'b1;
    if (clim_st.lamp_state != prev.lamp_state) r.change_mask[ChgLamp] = 1'b1;
    if (clim_st.curtain_state != prev.curtain_state) r.change_mask[ChgCurtain] = 1'b1;

    r.fan_speed_pct = pct;
    r.fan_duty = 8'(int'(pct) * 255 / 100);
    r.heater_on = clim_st.heater_state;
    r.lamp_on = clim_st.lamp_state;
    r.shade_open = clim_st.curtain_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Drive configuration writes and sensing ticks, predict on each accepted tick
  always @(posedge clk_i) begin
    item_t      nxt;
    reg_write_t wr;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        apply_reg(cfg_index, cfg_data);
        cfg_done++;
      end
      if (!cfg_valid || cfg_ready_o) begin
        if (reg_write_q.size() > 0 && !takes_break()) begin
          wr = reg_write_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= wr.idx;
          cfg_data <= wr.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end

      if (in_valid && !in_stall_o) expected_q.push_back(climate_tick(drv_tick));
      if (!in_valid || !in_stall_o) begin
        if (tick_q.size() > 0 && !takes_break()) begin
          nxt = tick_q.pop_front();
          in_valid <= 1'b1;
          drv_tick <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take results and compare against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = expected_q.pop_front();
        check_field("fan_speed_pct", want.fan_speed_pct, fan_speed_pct_o);
        check_field("fan_duty", want.fan_duty, fan_duty_o);
        check_field("heater_on", want.heater_on, heater_on_o);
        check_field("lamp_on", want.lamp_on, lamp_on_o);
        check_field("shade_open", want.shade_open, shade_open_o);
        check_field("change_mask", want.change_mask, change_mask_o);
        n_checked++;
      end
    end
    out_stall <= takes_break();
  end

  // Drop the run if nothing moves for too long; stray results do not count as progress
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) ||
        (out_valid_o && !out_stall && expected_q.size() > 0) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("no request moved for %0d cycles", QuietLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_tick(logic [31:0] up, int temp, int nh3, int h2s, int lux);
    item_t t;
    t.elapsed_ms = up;
    t.temperature_tenths = 12'(temp);
    t.ammonia_level = 16'(nh3);
    t.sulfide_level = 16'(h2s);
    t.light_lux = 16'(lux);
    tick_q.push_back(t);
    n_pushed++;
  endtask

  // Wait for all traffic to drain, then cover the pipeline latency
  task automatic settle();
    while (n_checked != n_pushed || cfg_done != cfg_pushed) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Queue one register write; bits above the register width are random
  task automatic post_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value, int w);
    reg_write_t wr;
    logic [31:0] keep;
    keep = (w >= 32) ? '1 : ((32'd1 << w) - 1);
    wr.idx = idx;
    wr.data = ($urandom() & ~keep) | (value & keep);
    reg_write_q.push_back(wr);
    cfg_pushed++;
  endtask

  task automatic program_regs(bit auto_on, int llo, int lhi, int tlo, int thi,
                              int nh3, int h2s, logic [31:0] warm);
    settle();
    post_reg(CfgAutoMode, 32'(auto_on), 1);
    post_reg(CfgLightLowLux, 32'(llo), 16);
    post_reg(CfgLightHighLux, 32'(lhi), 16);
    post_reg(CfgTempLow, 32'(tlo), 12);
    post_reg(CfgTempHigh, 32'(thi), 12);
    post_reg(CfgAmmoniaLimit, 32'(nh3), 16);
    post_reg(CfgSulfideLimit, 32'(h2s), 16);
    post_reg(CfgWarmupMs, warm, 32);
    settle();
    n_setups++;
  endtask

  function automatic logic [15:0] near16(logic [15:0] thr);
    return thr + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  function automatic logic [11:0] near12(logic [11:0] thr);
    return thr + 12'($urandom_range(0, 6)) - 12'd3;
  endfunction

  // Random tick, weighted toward the thresholds of the current setup
  function automatic item_t random_tick();
    item_t t;
    t.elapsed_ms = ($urandom_range(0, 3) == 0) ? $urandom() :
                   clim_cfg.warmup_ms + 32'($urandom_range(0, 8)) - 32'd4;
    case ($urandom_range(0, 7))
      0:       t.temperature_tenths = 12'($urandom());
      1, 2:    t.temperature_tenths = 12'(int'($urandom_range(0, 1650)) - 400);
      3, 4:    t.temperature_tenths = near12(clim_cfg.temp_low_tenths);
      default: t.temperature_tenths = near12(clim_cfg.temp_high_tenths);
    endcase
    case ($urandom_range(0, 3))
      0:       t.ammonia_level = 16'($urandom());
      1:       t.ammonia_level = near16(clim_cfg.ammonia_limit);
      default: t.ammonia_level = 16'($urandom_range(0, clim_cfg.ammonia_limit));
    endcase
    case ($urandom_range(0, 3))
      0:       t.sulfide_level = 16'($urandom());
      1:       t.sulfide_level = near16(clim_cfg.sulfide_limit);
      default: t.sulfide_level = 16'($urandom_range(0, clim_cfg.sulfide_limit));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: t.light_lux = (clim_cfg.light_high_lux != 16'hFFFF) ?
                 16'($urandom_range(int'(clim_cfg.light_high_lux) + 1, 65535)) :
                 16'($urandom());
      3, 4, 5: t.light_lux = (clim_cfg.light_low_lux != 16'h0) ?
                 16'($urandom_range(0, int'(clim_cfg.light_low_lux) - 1)) :
                 16'($urandom());
      6:       t.light_lux = near16(clim_cfg.light_low_lux);
      7:       t.light_lux = near16(clim_cfg.light_high_lux);
      default: t.light_lux = 16'($urandom());
    endcase
    return t;
  endfunction

  task automatic run_random(int count);
    repeat (count) begin
      tick_q.push_back(random_tick());
      n_pushed++;
    end
    settle();
  endtask

  // Random setup: light band mostly well ordered so the sequences run deep
  task automatic random_setup();
    int llo;
    llo = $urandom_range(0, 1000);
    program_regs($urandom_range(0, 3) != 0, llo, llo + $urandom_range(0, 3000),
                 int'($urandom_range(0, 1650)) - 400, int'($urandom_range(0, 1650)) - 400,
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 100000)) : $urandom());
  endtask

  // Reset, directed sequences, then random setups
  initial begin
    clim_cfg.auto_ctrl = AutoModeRst;
    clim_cfg.light_low_lux = LightLowRst;
    clim_cfg.light_high_lux = LightHighRst;
    clim_cfg.temp_low_tenths = TempLowRst;
    clim_cfg.temp_high_tenths = TempHighRst;
    clim_cfg.ammonia_limit = AmmoniaLimitRst;
    clim_cfg.sulfide_limit = SulfideLimitRst;
    clim_cfg.warmup_ms = WarmupMsRst;
    clim_st = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first tick, then walk the light sequence through every branch
    queue_tick(0, 220, 0, 0, 200);
    queue_tick(0, 220, 0, 0, 10);
    queue_tick(1000, 220, 0, 0, 10);
    queue_tick(2000, 220, 0, 0, 600);
    queue_tick(3000, 220, 0, 0, 600);
    queue_tick(4000, 220, 0, 0, 65535);
    queue_tick(5000, 220, 0, 0, 0);
    queue_tick(6000, 220, 0, 0, 80);
    queue_tick(7000, 220, 0, 0, 500);
    // gas limits around the end of warm-up
    queue_tick(59999, 220, 65535, 65535, 200);
    queue_tick(60000, 220, 1501, 0, 200);
    queue_tick(60000, 220, 1500, 800, 200);
    queue_tick(70000, 220, 0, 801, 200);
    // temperature edges
    queue_tick(32'hFFFF_FFFF, 251, 0, 0, 200);
    queue_tick(32'hFFFF_FFFF, 250, 0, 0, 200);
    queue_tick(100, 199, 0, 0, 200);
    queue_tick(100, -400, 0, 0, 200);
    queue_tick(100, 1250, 0, 0, 200);
    queue_tick(100, 200, 0, 0, 200);
    settle();

    // manual mode with crossed temperature limits
    program_regs(1'b0, 80, 500, 300, 100, 1500, 800, 60000);
    queue_tick(100, 200, 0, 0, 10);
    queue_tick(100, 350, 0, 0, 600);
    queue_tick(100, -2048, 0, 0, 0);
    queue_tick(100, 2047, 0, 0, 65535);
    settle();

    // extremes of every register
    program_regs(1'b1, 0, 0, -400, -400, 0, 0, 0);
    run_random(200);
    program_regs(1'b1, 65535, 65535, 1250, 1250, 65535, 65535, 32'hFFFF_FFFF);
    run_random(150);
    // thresholds outside the documented span
    program_regs(1'b1, 80, 500, -2048, 2047, 1500, 800, 60000);
    run_random(200);

    repeat (5) begin
      random_setup();
      run_random(190);
    end

    // long burst with neither side pausing
    random_setup();
    no_idle = 1'b1;
    run_random(230);
    no_idle = 1'b0;

    settle();
    $display("Covered %0d sensing ticks across %0d register setups (%0d register writes).",
             n_checked, n_setups, cfg_done);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ climate_fan_heat_light_controller_core.f @@
rtl/cfhl_pkg.sv
rtl/cfhl_decide.sv
rtl/climate_fan_heat_light_controller_core.sv
tb/sv/tb.sv
